// File: src/icsp_pkg.sv
`timescale 1ns / 1ps
package icsp_pkg;

  localparam int unsigned MAX_NAME_LEN_DEF  = 256;
  localparam int unsigned MAX_VALUE_LEN_DEF = 1024;
  localparam int unsigned MAX_RES           = 4;

  localparam logic [2:0] K_SEC_CHAR  = 3'd0;
  localparam logic [2:0] K_SEC_END   = 3'd1;
  localparam logic [2:0] K_KEY_CHAR  = 3'd2;
  localparam logic [2:0] K_VAL_CHAR  = 3'd3;
  localparam logic [2:0] K_END_VALUE = 3'd4;
  localparam logic [2:0] K_END_BOOL  = 3'd5;
  localparam logic [2:0] K_FINISHED  = 3'd6;
  localparam logic [2:0] K_ERROR     = 3'd7;

  localparam logic [2:0] E_BOM        = 3'd0;
  localparam logic [2:0] E_LINE_START = 3'd1;
  localparam logic [2:0] E_SECTION    = 3'd2;
  localparam logic [2:0] E_NAME_LONG  = 3'd3;
  localparam logic [2:0] E_NO_EQUALS  = 3'd4;
  localparam logic [2:0] E_VALUE_LONG = 3'd5;
  localparam logic [2:0] E_OPEN_QUOTE = 3'd6;
  localparam logic [2:0] E_ESCAPE     = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  character;
    logic [19:0] line_number;
    logic [2:0]  error_code;
  } res_t;

  typedef struct packed {
    logic [2:0]           cnt;
    res_t [MAX_RES-1:0]   res;
  } entry_t;

endpackage

// File: src/icsp_if.sv
`timescale 1ns / 1ps
interface icsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_file;
  modport source (output valid, output byte_in, output end_of_file, input ready);
  modport sink (input valid, input byte_in, input end_of_file, output ready);
endinterface

interface icsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  character;
  logic [19:0] line_number;
  logic [2:0]  error_code;
  logic        last;
  modport source (output valid, output kind, output character, output line_number,
                  output error_code, output last, input ready);
  modport sink (input valid, input kind, input character, input line_number,
                input error_code, input last, output ready);
endinterface

// File: src/icsp_front.sv
`timescale 1ns / 1ps
module icsp_front
  import icsp_pkg::*;
#(
  parameter int unsigned MAX_NAME_LEN  = MAX_NAME_LEN_DEF,
  parameter int unsigned MAX_VALUE_LEN = MAX_VALUE_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       end_of_file,
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_data
);

  localparam logic [7:0]  SEC_LIM  = 8'(MAX_NAME_LEN / 2);
  localparam logic [8:0]  NAME_LIM = 9'(MAX_NAME_LEN);
  localparam logic [10:0] VAL_LIM  = 11'(MAX_VALUE_LEN - 1);
  localparam logic [7:0] LF = 8'h0A;
  localparam logic [7:0] CR = 8'h0D;

  typedef enum logic [2:0] {
    M_TOP, M_SECTION, M_KEY, M_KEY_SPACE, M_VALUE, M_ESCAPE, M_HALT
  } mode_t;

  // The value length can step past the limit by one, so it carries a spare bit.
  typedef struct packed {
    mode_t       mode;
    logic [1:0]  bom;
    logic        cr;
    logic        inq;
    logic        incom;
    logic        sp;
    logic [7:0]  sec;
    logic [8:0]  nlen;
    logic [10:0] vlen;
    logic [19:0] line;
  } pst_t;

  typedef struct packed {
    pst_t   st;
    entry_t acc;
  } work_t;

  pst_t  st_r, st_nxt;
  work_t w;

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_name(logic [7:0] c);
    return is_alpha(c) || (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] bom_byte(logic [1:0] p);
    case (p)
      2'd0: return 8'hEF;
      2'd1: return 8'hBB;
      default: return 8'hBF;
    endcase
  endfunction

  function automatic work_t emit(work_t wi, logic [2:0] k, logic [7:0] ch, logic [2:0] e);
    work_t r;
    r = wi;
    if (r.acc.cnt < 3'(MAX_RES)) begin
      r.acc.res[r.acc.cnt[1:0]] = '{kind: k, character: ch, line_number: r.st.line,
                                    error_code: e};
      r.acc.cnt = r.acc.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic work_t fail(work_t wi, logic [2:0] e);
    work_t r;
    r = emit(wi, K_ERROR, 8'd0, e);
    r.st.mode = M_HALT;
    return r;
  endfunction

  function automatic work_t end_key(work_t wi, logic [7:0] c);
    work_t r;
    r = wi;
    if (c == " " || c == 8'h09) begin
      r.st.mode = M_KEY_SPACE;
    end else if (c == LF) begin
      r = emit(r, K_END_BOOL, 8'd0, 3'd0);
      r.st.mode = M_TOP;
    end else if (c == "=") begin
      r.st.inq = 1'b0;
      r.st.incom = 1'b0;
      r.st.sp = 1'b0;
      r.st.vlen = '0;
      r.st.mode = M_VALUE;
    end else begin
      r = fail(r, E_NO_EQUALS);
    end
    return r;
  endfunction

  function automatic work_t feed(work_t wi, logic [7:0] ci, logic eof);
    work_t      r;
    logic       done;
    logic [7:0] c;
    r = wi;
    c = ci;
    done = 1'b0;
    if (c == LF && !eof && r.st.line != '1) r.st.line = r.st.line + 20'd1;
    if (r.st.mode == M_HALT) done = 1'b1;
    if (!done && r.st.mode == M_TOP && r.st.bom != 2'd3) begin
      if (c == bom_byte(r.st.bom)) begin
        r.st.bom = r.st.bom + 2'd1;
        done = 1'b1;
      end else if (r.st.bom != 2'd0) begin
        r = fail(r, E_BOM);
        done = 1'b1;
      end else begin
        r.st.bom = 2'd3;
      end
    end
    if (!done) begin
      case (r.st.mode)
        M_TOP: begin
          if (c == LF) begin
            r.st.incom = 1'b0;
          end else if (r.st.incom || is_space(c)) begin
            r.st.incom = r.st.incom;
          end else if (c == "#" || c == ";") begin
            r.st.incom = 1'b1;
          end else if (c == "[") begin
            r.st.sec = '0;
            r.st.mode = M_SECTION;
          end else if (is_alpha(c)) begin
            r.st.nlen = ((r.st.sec != '0) ? 9'(r.st.sec) + 9'd1 : 9'd0) + 9'd1;
            r = emit(r, K_KEY_CHAR, to_lower(c), 3'd0);
            r.st.mode = M_KEY;
          end else begin
            r = fail(r, E_LINE_START);
          end
        end
        M_SECTION: begin
          if (eof) begin
            r = fail(r, E_SECTION);
          end else if (c == "]") begin
            if (r.st.sec == '0) begin
              r = fail(r, E_SECTION);
            end else begin
              r = emit(r, K_SEC_END, 8'd0, 3'd0);
              r.st.mode = M_TOP;
            end
          end else if (!is_name(c)) begin
            r = fail(r, E_SECTION);
          end else if (r.st.sec > SEC_LIM) begin
            r = fail(r, E_NAME_LONG);
          end else begin
            r = emit(r, K_SEC_CHAR, to_lower(c), 3'd0);
            r.st.sec = r.st.sec + 8'd1;
          end
        end
        M_KEY: begin
          if (eof || !is_name(c)) begin
            r = end_key(r, c);
          end else begin
            r = emit(r, K_KEY_CHAR, to_lower(c), 3'd0);
            r.st.nlen = r.st.nlen + 9'd1;
            if (r.st.nlen >= NAME_LIM) r = fail(r, E_NAME_LONG);
          end
        end
        M_KEY_SPACE: begin
          if (c != " " && c != 8'h09) r = end_key(r, c);
        end
        M_VALUE: begin
          if (r.st.vlen >= VAL_LIM) begin
            r = fail(r, E_VALUE_LONG);
          end else if (c == LF) begin
            if (r.st.inq) begin
              r = fail(r, E_OPEN_QUOTE);
            end else begin
              r = emit(r, K_END_VALUE, 8'd0, 3'd0);
              r.st.incom = 1'b0;
              r.st.mode = M_TOP;
            end
          end else if (r.st.incom) begin
            r.st.incom = 1'b1;
          end else if (is_space(c) && !r.st.inq) begin
            r.st.sp = 1'b1;
          end else if (!r.st.inq && (c == ";" || c == "#")) begin
            r.st.incom = 1'b1;
          end else begin
            if (r.st.sp) begin
              if (r.st.vlen != '0) begin
                r = emit(r, K_VAL_CHAR, 8'h20, 3'd0);
                r.st.vlen = r.st.vlen + 11'd1;
              end
              r.st.sp = 1'b0;
            end
            if (c == "\\") begin
              r.st.mode = M_ESCAPE;
            end else if (c == "\"") begin
              r.st.inq = !r.st.inq;
            end else begin
              r = emit(r, K_VAL_CHAR, c, 3'd0);
              r.st.vlen = r.st.vlen + 11'd1;
            end
          end
        end
        M_ESCAPE: begin
          r.st.mode = M_VALUE;
          if (c != LF) begin
            if (c == "t" || c == "b" || c == "n" || c == "\\" || c == "\"") begin
              if (c == "t") c = 8'h09;
              else if (c == "b") c = 8'h08;
              else if (c == "n") c = LF;
              r = emit(r, K_VAL_CHAR, c, 3'd0);
              r.st.vlen = r.st.vlen + 11'd1;
            end else begin
              r = fail(r, E_ESCAPE);
            end
          end
        end
        default: r.st.mode = M_HALT;
      endcase
    end
    return r;
  endfunction

  always_comb begin
    w = '0;
    w.st = st_r;
    w.acc.cnt = '0;
    if (end_of_file) begin
      if (w.st.cr) begin
        w.st.cr = 1'b0;
        w = feed(w, CR, 1'b0);
      end
      for (int i = 0; i < 3; i++) begin
        if (w.st.mode != M_HALT) begin
          w = feed(w, LF, 1'b1);
          if (w.st.mode == M_TOP) begin
            w = emit(w, K_FINISHED, 8'd0, 3'd0);
            w.st.mode = M_HALT;
          end
        end
      end
    end else if (w.st.cr) begin
      if (byte_in == LF) begin
        w.st.cr = 1'b0;
        w = feed(w, LF, 1'b0);
      end else if (byte_in == CR) begin
        w = feed(w, CR, 1'b0);
      end else begin
        w.st.cr = 1'b0;
        w = feed(w, CR, 1'b0);
        w = feed(w, byte_in, 1'b0);
      end
    end else if (byte_in == CR) begin
      w.st.cr = 1'b1;
    end else begin
      w = feed(w, byte_in, 1'b0);
    end
    st_nxt = w.st;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && (w.acc.cnt != '0);
  assign q_data   = w.acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode: M_TOP, default: '0};
    end else if (in_valid && in_ready) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: src/icsp_fifo.sv
`timescale 1ns / 1ps
module icsp_fifo
  import icsp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t wdata,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t rdata
);

  entry_t     mem [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
`endif

endmodule

// File: src/icsp_back.sv
`timescale 1ns / 1ps
module icsp_back
  import icsp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_empty,
  input  entry_t q_data,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   out_res,
  output logic   out_last
);

  entry_t     cur_r;
  logic [1:0] idx_r;
  logic       busy_r;
  logic       fin;

  assign fin       = busy_r && out_ready && out_last;
  assign q_pop     = !q_empty && (!busy_r || fin);
  assign out_valid = busy_r;
  assign out_res   = cur_r.res[idx_r];
  assign out_last  = (3'(idx_r) + 3'd1) == cur_r.cnt;

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (fin) begin
      busy_r <= 1'b0;
    end else if (busy_r && out_ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (3'(idx_r) < cur_r.cnt))
    else $error("result index beyond entry count");
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_res.kind == K_ERROR) |-> out_last)
    else $error("error beat is not the final beat");
  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_res.kind == K_FINISHED) |-> out_last)
    else $error("finished beat is not the final beat");
`endif

endmodule

// File: src/ini_config_stream_parser_unit.sv
`timescale 1ns / 1ps
// INI configuration stream parser.
// The input channel carries one raw byte per beat, or an end-of-file mark.
// The output channel carries tagged results: section and key characters
// (lowercased), decoded value characters, entry ends, the finished mark and
// errors with their code and line number; last marks the final beat of an item.
// The front stage decodes one input beat per cycle while the queue is not full
// and writes the one to four results the beat causes, if any, as one entry
// into a two-entry queue. The back stage plays each entry out at one result
// per cycle while the receiver is ready, so throughput is one input beat per
// cycle while each beat yields at most one result. Results pass the queue and
// then the back stage's result register on their way to the output.
// Reset clears the parse state, the queue and the output stage.
// When the receiver stalls, the queue fills and input ready drops.
// After an error or the finished mark, further input is taken and ignored.
module ini_config_stream_parser_unit
  import icsp_pkg::*;
#(
  parameter int unsigned MAX_NAME_LEN  = MAX_NAME_LEN_DEF,
  parameter int unsigned MAX_VALUE_LEN = MAX_VALUE_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  icsp_in_if.sink   in_if,
  icsp_out_if.source out_if
);

  logic   q_full, q_push, q_pop, q_empty;
  entry_t q_wdata, q_rdata;
  res_t   res;

  icsp_front #(.MAX_NAME_LEN(MAX_NAME_LEN), .MAX_VALUE_LEN(MAX_VALUE_LEN)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .byte_in(in_if.byte_in), .end_of_file(in_if.end_of_file),
    .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
  );

  icsp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  icsp_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .out_res(res), .out_last(out_if.last)
  );

  assign out_if.kind        = res.kind;
  assign out_if.character   = res.character;
  assign out_if.line_number = res.line_number;
  assign out_if.error_code  = res.error_code;

endmodule
